// ===== rtl/dcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Display command frame builder package
// Shared types, constants and the CRC16 byte update for the frame builder.
// ----------------------------------------------------------------------------
package dcfb_pkg;

  // Longest burst one input can cause: six header bytes, one payload byte
  // and two CRC bytes on a one-byte frame with a two-byte address.
  localparam int FRAME_MAX_BYTES = 9;
  localparam int POS_W           = $clog2(FRAME_MAX_BYTES + 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] LEN_EXTRA_REG = 8'd4;
  localparam logic [7:0] LEN_EXTRA_MEM = 8'd5;

  // Frame kinds carried on in_cmd.
  localparam logic [1:0] CMD_WRITE_REG = 2'd0;
  localparam logic [1:0] CMD_READ_REG  = 2'd1;
  localparam logic [1:0] CMD_WRITE_MEM = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_WR_REG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_RD_REG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_WR_MEM   = 3'd4;

  typedef logic [FRAME_MAX_BYTES-1:0][7:0] frame_bytes_t;

  // One burst of result bytes handed to the output serializer.
  typedef struct packed {
    frame_bytes_t     bytes;
    logic [POS_W-1:0] count;
    logic             ends_frame;
  } frame_load_t;

  // Modbus CRC16 update by one byte, reflected form.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/dcfb_serializer.sv =====
// ----------------------------------------------------------------------------
// Frame builder output serializer
// Holds one burst of up to nine bytes and sends it one byte per transaction.
// ----------------------------------------------------------------------------
module dcfb_serializer
  import dcfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_valid,
  input  frame_load_t load,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic        out_run_last
);

  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] count_r;
  logic             ends_frame_r;
  frame_bytes_t     bytes_r;
  logic             at_last;
  logic             out_fire;

  assign at_last  = (idx_r == count_r - POS_W'(1));
  assign out_fire = out_valid && out_ready;
  // The buffer may be refilled in the cycle its last byte leaves.
  assign can_load = !busy_r || (out_fire && at_last);

  assign out_valid     = busy_r;
  assign out_byte      = bytes_r[idx_r];
  assign out_run_last  = at_last;
  assign out_frame_end = at_last && ends_frame_r;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load_valid && can_load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (out_fire) begin
      if (at_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && can_load) begin
      bytes_r      <= load.bytes;
      count_r      <= load.count;
      ends_frame_r <= load.ends_frame;
    end
  end

endmodule

// ===== rtl/display_command_frame_builder_top.sv =====
// ----------------------------------------------------------------------------
// Display command frame builder
// Wraps payload bytes into serial display command frames with a CRC16.
// ----------------------------------------------------------------------------
// Each input transaction carries one payload byte. On the first byte of a
// frame the fields in_cmd, in_target and in_payload_count select the frame
// kind, address and length; they are ignored on later bytes. The first byte
// produces the header, length, command code and address bytes followed by
// the payload byte; the last byte is followed by the Modbus CRC16, low byte
// first. Each output transaction carries one byte; out_run_last marks the
// final byte caused by an input and out_frame_end the last CRC byte.
// An accepted input is held in the input register, then its burst is built
// in a single pass into the output buffer, from which its first byte
// appears. The output sends one byte per cycle while out_ready is high; the
// input register takes the next transaction while the burst drains. When
// the receiver stalls, the output holds and the input side fills and then
// deasserts in_ready. Reset restores the default configuration values,
// empties both registers and starts a new frame. Configuration is written
// through cfg_we, cfg_index and cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module display_command_frame_builder_top
  import dcfb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 250
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [15:0]          in_target,
  input  logic [7:0]           in_payload_count,
  input  logic [7:0]           in_payload_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_frame_end,
  output logic                 out_run_last
);

  localparam logic [7:0] MaxCount = 8'(MAX_PAYLOAD);

  // Configuration registers.
  logic [7:0] header_first_r, header_second_r;
  logic [7:0] code_wr_reg_r, code_rd_reg_r, code_wr_mem_r;

  // Input register and values prepared at capture.
  logic        hold_full_r;
  logic        hold_mem_r;
  logic [15:0] hold_target_r;
  logic [7:0]  hold_cnt_r;
  logic [7:0]  hold_len_r;
  logic [7:0]  hold_code_r;
  logic [7:0]  hold_data_r;
  logic [15:0] hold_hcrc_r;

  // Frame state.
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;

  logic        in_fire;
  logic        load_fire;
  logic        can_load;

  logic        cap_mem;
  logic [7:0]  cap_cnt;
  logic [7:0]  cap_code;
  logic [15:0] cap_hcrc;

  logic             start;
  logic [7:0]       left_now;
  logic [7:0]       left_after;
  logic [15:0]      crc_new;
  logic             done;
  logic [POS_W-1:0] pos;
  frame_load_t      load;

  assign in_fire   = in_valid && in_ready;
  assign load_fire = hold_full_r && can_load;
  assign in_ready  = !hold_full_r || load_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= 8'h5A;
      header_second_r <= 8'hA5;
      code_wr_reg_r   <= 8'h80;
      code_rd_reg_r   <= 8'h81;
      code_wr_mem_r   <= 8'h82;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_FIRST:  header_first_r  <= cfg_wdata;
        REG_HEADER_SECOND: header_second_r <= cfg_wdata;
        REG_CODE_WR_REG:   code_wr_reg_r   <= cfg_wdata;
        REG_CODE_RD_REG:   code_rd_reg_r   <= cfg_wdata;
        REG_CODE_WR_MEM:   code_wr_mem_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame-head values are worked out for every transaction; they are used
  // only if the transaction turns out to open a frame.
  always_comb begin
    cap_mem = (in_cmd != CMD_WRITE_REG) && (in_cmd != CMD_READ_REG);
    cap_cnt = in_payload_count;
    if (cap_cnt == 8'd0) begin
      cap_cnt = 8'd1;
    end
    if (cap_cnt > MaxCount) begin
      cap_cnt = MaxCount;
    end
    if (in_cmd == CMD_READ_REG) begin
      cap_cnt = 8'd1;
    end
    if (cap_mem) begin
      cap_code = code_wr_mem_r;
    end else if (in_cmd == CMD_READ_REG) begin
      cap_code = code_rd_reg_r;
    end else begin
      cap_code = code_wr_reg_r;
    end
    cap_hcrc = crc_byte(CRC_INIT, cap_code);
    if (cap_mem) begin
      cap_hcrc = crc_byte(cap_hcrc, in_target[15:8]);
    end
    cap_hcrc = crc_byte(cap_hcrc, in_target[7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_full_r <= 1'b0;
    end else if (in_fire) begin
      hold_full_r <= 1'b1;
    end else if (load_fire) begin
      hold_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_mem_r    <= cap_mem;
      hold_target_r <= in_target;
      hold_cnt_r    <= cap_cnt;
      hold_len_r    <= cap_cnt + (cap_mem ? LEN_EXTRA_MEM : LEN_EXTRA_REG);
      hold_code_r   <= cap_code;
      hold_data_r   <= in_payload_byte;
      hold_hcrc_r   <= cap_hcrc;
    end
  end

  // Burst assembly for the held transaction.
  always_comb begin
    start      = (bytes_left_r == 8'd0);
    left_now   = start ? hold_cnt_r : bytes_left_r;
    left_after = left_now - 8'd1;
    crc_new    = crc_byte(start ? hold_hcrc_r : crc_acc_r, hold_data_r);
    done       = (left_after == 8'd0);
    load       = '0;
    pos        = '0;
    if (start) begin
      load.bytes[0] = header_first_r;
      load.bytes[1] = header_second_r;
      load.bytes[2] = hold_len_r;
      load.bytes[3] = hold_code_r;
      if (hold_mem_r) begin
        load.bytes[4] = hold_target_r[15:8];
        load.bytes[5] = hold_target_r[7:0];
        pos           = POS_W'(6);
      end else begin
        load.bytes[4] = hold_target_r[7:0];
        pos           = POS_W'(5);
      end
    end
    load.bytes[pos] = hold_data_r;
    pos             = pos + POS_W'(1);
    if (done) begin
      load.bytes[pos]              = crc_new[7:0];
      load.bytes[pos + POS_W'(1)]  = crc_new[15:8];
      pos                          = pos + POS_W'(2);
    end
    load.count      = pos;
    load.ends_frame = done;

    bytes_left_nxt = bytes_left_r;
    crc_acc_nxt    = crc_acc_r;
    if (load_fire) begin
      bytes_left_nxt = left_after;
      crc_acc_nxt    = done ? CRC_INIT : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= 8'd0;
      crc_acc_r    <= CRC_INIT;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      crc_acc_r    <= crc_acc_nxt;
    end
  end

  dcfb_serializer u_ser (
    .clk           (clk),
    .rst_n         (rst_n),
    .load_valid    (hold_full_r),
    .load          (load),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

  // The CRC byte that closes a frame is always the last byte of its burst.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("frame end without run end");

  // The remaining payload count never exceeds MAX_PAYLOAD.
  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r <= MaxCount)
    else $error("payload count out of range");

  // A burst handed to the output is visible in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> out_valid)
    else $error("loaded burst not presented");

  // Input backpressure only comes from a full input register.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> hold_full_r && !can_load)
    else $error("input stalled without cause");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display command frame builder testbench
// Drives payload bytes through the frame builder under several configuration
// settings and idle mixes, and checks every output byte against a predictor
// that builds the frame head, the payload and the Modbus CRC16.
// ----------------------------------------------------------------------------
module testbench;
  import dcfb_pkg::*;

  localparam int MAX_PAYLOAD  = 250;
  localparam int NUM_CFG_REGS = 5;
  localparam int DRAIN_GAP    = 16;
  localparam int HOLD_CYCLES  = 80;
  localparam int CYCLE_LIMIT  = 300000;

  // The package names three frame kinds; the fourth code builds a memory frame.
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [7:0] DEF_HEADER_FIRST  = 8'h5A;
  localparam logic [7:0] DEF_HEADER_SECOND = 8'hA5;
  localparam logic [7:0] DEF_CODE_WR_REG   = 8'h80;
  localparam logic [7:0] DEF_CODE_RD_REG   = 8'h81;
  localparam logic [7:0] DEF_CODE_WR_MEM   = 8'h82;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] target;
    logic [7:0]  count;
    logic [7:0]  data;
  } payload_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       frame_end;
    logic       run_last;
  } stream_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd = 2'd0;
  logic [15:0]          in_target = 16'h0000;
  logic [7:0]           in_payload_count = 8'h00;
  logic [7:0]           in_payload_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_frame_end;
  logic                 out_run_last;

  display_command_frame_builder_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_target       (in_target),
    .in_payload_count(in_payload_count),
    .in_payload_byte (in_payload_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .out_run_last    (out_run_last)
  );

  payload_item_t pending_items[$];
  stream_byte_t  expected_bytes[$];

  logic [7:0]  cfg_shadow [NUM_CFG_REGS] = '{DEF_HEADER_FIRST, DEF_HEADER_SECOND,
                                             DEF_CODE_WR_REG, DEF_CODE_RD_REG,
                                             DEF_CODE_WR_MEM};
  logic [7:0]  frame_left = 8'd0;
  logic [15:0] crc_run = CRC_INIT;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ 16'hA001) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic void push_byte(input logic [7:0] value, input logic fe, input logic last);
    stream_byte_t sb;
    sb.value = value;
    sb.frame_end = fe;
    sb.run_last = last;
    expected_bytes.push_back(sb);
  endfunction

  // Works out the output bytes caused by one accepted payload transaction.
  function automatic void frame_predict(input payload_item_t it);
    logic [7:0] eff;
    logic [7:0] code;
    if (frame_left == 8'd0) begin
      eff = it.count;
      if (eff == 8'd0) eff = 8'd1;
      if (eff > MAX_PAYLOAD) eff = 8'(MAX_PAYLOAD);
      if (it.cmd == CMD_READ_REG) eff = 8'd1;
      push_byte(cfg_shadow[REG_HEADER_FIRST], 1'b0, 1'b0);
      push_byte(cfg_shadow[REG_HEADER_SECOND], 1'b0, 1'b0);
      crc_run = CRC_INIT;
      if (it.cmd == CMD_WRITE_REG || it.cmd == CMD_READ_REG) begin
        code = (it.cmd == CMD_WRITE_REG) ? cfg_shadow[REG_CODE_WR_REG]
                                         : cfg_shadow[REG_CODE_RD_REG];
        push_byte(eff + LEN_EXTRA_REG, 1'b0, 1'b0);
        push_byte(code, 1'b0, 1'b0);
        push_byte(it.target[7:0], 1'b0, 1'b0);
        crc_run = crc16_step(crc_run, code);
        crc_run = crc16_step(crc_run, it.target[7:0]);
      end else begin
        code = cfg_shadow[REG_CODE_WR_MEM];
        push_byte(eff + LEN_EXTRA_MEM, 1'b0, 1'b0);
        push_byte(code, 1'b0, 1'b0);
        push_byte(it.target[15:8], 1'b0, 1'b0);
        push_byte(it.target[7:0], 1'b0, 1'b0);
        crc_run = crc16_step(crc_run, code);
        crc_run = crc16_step(crc_run, it.target[15:8]);
        crc_run = crc16_step(crc_run, it.target[7:0]);
      end
      frame_left = eff;
    end
    crc_run = crc16_step(crc_run, it.data);
    frame_left = frame_left - 8'd1;
    push_byte(it.data, 1'b0, frame_left != 8'd0);
    if (frame_left == 8'd0) begin
      push_byte(crc_run[7:0], 1'b0, 1'b0);
      push_byte(crc_run[15:8], 1'b1, 1'b1);
      crc_run = CRC_INIT;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)", what, got, want,
             cycle_count);
    error_count++;
  endtask

  // Driver: offers queued payload transactions, idling at random.
  always @(posedge clk) begin
    payload_item_t staged;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        staged = pending_items.pop_front();
        in_valid <= 1'b1;
        in_cmd <= staged.cmd;
        in_target <= staged.target;
        in_payload_count <= staged.count;
        in_payload_byte <= staged.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each accepted input and checks each accepted output.
  always @(posedge clk) begin
    payload_item_t seen;
    stream_byte_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        seen.cmd = in_cmd;
        seen.target = in_target;
        seen.count = in_payload_count;
        seen.data = in_payload_byte;
        frame_predict(seen);
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected output byte", out_byte, 0);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value)
            report_mismatch("out_byte", out_byte, want.value);
          if (out_frame_end !== want.frame_end)
            report_mismatch("out_frame_end", out_frame_end, want.frame_end);
          if (out_run_last !== want.run_last)
            report_mismatch("out_run_last", out_run_last, want.run_last);
          if (want.frame_end) frames_closed++;
        end
        bytes_checked++;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d bytes still expected", cycle_count,
               expected_bytes.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_CFG_REGS) cfg_shadow[idx] = value;
  endtask

  task automatic apply_settings(input logic [7:0] h1, input logic [7:0] h2,
                                input logic [7:0] wr, input logic [7:0] rd,
                                input logic [7:0] mem);
    write_reg(REG_HEADER_FIRST, h1);
    write_reg(REG_HEADER_SECOND, h2);
    write_reg(REG_CODE_WR_REG, wr);
    write_reg(REG_CODE_RD_REG, rd);
    write_reg(REG_CODE_WR_MEM, mem);
  endtask

  // Queues one whole frame. Fields after the first byte are random, since the
  // block must ignore them. With split_at set, the sender pauses mid-frame
  // until the block has drained.
  task automatic add_frame(input logic [1:0] kind, input logic [15:0] addr,
                           input logic [7:0] count, input logic [7:0] first_data,
                           input int split_at);
    int n;
    payload_item_t it;
    n = (count == 8'd0) ? 1 : (count > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(count);
    if (kind == CMD_READ_REG) n = 1;
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        it.cmd = kind;
        it.target = addr;
        it.count = count;
        it.data = first_data;
      end else begin
        it.cmd = 2'($urandom_range(3));
        it.target = 16'($urandom);
        it.count = 8'($urandom);
        it.data = 8'($urandom);
      end
      pending_items.push_back(it);
      items_queued++;
      if (split_at != 0 && i + 1 == split_at) wait_drained();
    end
  endtask

  task automatic add_random_frames(input int n_items);
    int start;
    int pick;
    logic [1:0] kind;
    logic [7:0] count;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(9);
      kind = (pick < 3) ? CMD_WRITE_REG : (pick < 5) ? CMD_READ_REG :
             (pick < 9) ? CMD_WRITE_MEM : CMD_RESERVED;
      pick = $urandom_range(11);
      if (kind == CMD_READ_REG) count = 8'($urandom);
      else if (pick == 0) count = 8'd0;
      else if (pick == 1) count = 8'($urandom_range(7, 20));
      else count = 8'($urandom_range(1, 6));
      add_frame(kind, 16'($urandom), count, 8'($urandom), 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset configuration, no idling.
    add_frame(CMD_WRITE_REG, 16'h0000, 8'd1, 8'h00, 0);
    add_frame(CMD_WRITE_REG, 16'hFFFF, 8'd1, 8'hFF, 0);
    add_frame(CMD_WRITE_REG, 16'h1234, 8'd0, 8'h5A, 0);
    add_frame(CMD_READ_REG, 16'h00A0, 8'd0, 8'h10, 0);
    add_frame(CMD_READ_REG, 16'hFF3C, 8'd255, 8'hFF, 0);
    add_frame(CMD_WRITE_MEM, 16'hFFFF, 8'd1, 8'hA5, 0);
    add_frame(CMD_WRITE_MEM, 16'h0000, 8'd0, 8'h00, 0);
    add_frame(CMD_RESERVED, 16'h8001, 8'd2, 8'h7E, 0);
    add_frame(CMD_WRITE_REG, 16'h00C3, 8'd3, 8'h01, 0);
    add_frame(CMD_WRITE_MEM, 16'hBEEF, 8'd4, 8'h80, 0);
    wait_drained();

    // All codes zero; indexes past the register list must change nothing.
    apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int idx = NUM_CFG_REGS; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), 8'hFF);
    send_idle_pct = 65;
    stall_pct = 0;
    add_random_frames(40);
    wait_drained();

    // All codes at their top value; the receiver stalls and holds off a while.
    apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_idle_pct = 0;
    stall_pct = 65;
    @(posedge clk);
    hold_requests <= hold_requests + 1;
    add_random_frames(40);
    wait_drained();

    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 36;
    stall_pct = 36;
    add_random_frames(20);
    add_frame(CMD_WRITE_MEM, 16'($urandom), 8'd8, 8'($urandom), 3);
    add_random_frames(20);
    wait_drained();

    // Back to the reset values, then a long frame.
    apply_settings(DEF_HEADER_FIRST, DEF_HEADER_SECOND, DEF_CODE_WR_REG,
                   DEF_CODE_RD_REG, DEF_CODE_WR_MEM);
    send_idle_pct = 0;
    stall_pct = 0;
    add_frame(CMD_WRITE_MEM, 16'($urandom), 8'd60, 8'($urandom), 0);
    add_random_frames(20);
    wait_drained();

    $display("Run covered %0d payload transactions, %0d output bytes, %0d frames,",
             items_accepted, bytes_checked, frames_closed);
    $display("five register settings, idle and stall mixes, one hold-off and a long frame.");
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
